// File: design/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, register offsets, codes and wave tables of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int VOICES_DEF      = 8;
    localparam int SAMPLE_RATE_DEF = 24000;

    localparam logic [31:0] NOISE_MIX_INIT = 32'h6745_2301;
    localparam logic [31:0] NOISE_OUT_INIT = 32'hEFCD_AB89;

    localparam logic signed [15:0] WAVE_PEAK = 16'sd32767;
    localparam logic signed [15:0] WAVE_RAIL = -16'sd32767;

    // register byte offsets inside a voice
    localparam logic [2:0] OFF_FREQ_LO  = 3'd0;
    localparam logic [2:0] OFF_FREQ_HI  = 3'd1;
    localparam logic [2:0] OFF_DUTY     = 3'd2;
    localparam logic [2:0] OFF_ATTACK   = 3'd3;
    localparam logic [2:0] OFF_DECAY    = 3'd4;
    localparam logic [2:0] OFF_RELEASE  = 3'd5;
    localparam logic [2:0] OFF_PAN_GATE = 3'd6;

    // envelope stages
    localparam logic [1:0] STG_RELEASE = 2'd0;
    localparam logic [1:0] STG_ATTACK  = 2'd1;
    localparam logic [1:0] STG_DECAY   = 2'd2;
    localparam logic [1:0] STG_SUSTAIN = 2'd3;

    // wave codes
    localparam logic [3:0] WAVE_SINE     = 4'd0;
    localparam logic [3:0] WAVE_SQUARE   = 4'd1;
    localparam logic [3:0] WAVE_SAW      = 4'd2;
    localparam logic [3:0] WAVE_TRIANGLE = 4'd3;
    localparam logic [3:0] WAVE_NOISE    = 4'd4;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic [7:0][7:0]    regs;
        logic [31:0]        inc;
        logic signed [15:0] sample;
        logic [31:0]        phase;
        logic [24:0]        env;
        logic [1:0]         stage;
        logic [31:0]        nmix;
        logic [31:0]        nout;
        logic [2:0]         pend;
    } voice_t;

    typedef struct packed {
        logic       en;
        logic [2:0] off;
        logic [7:0] data;
    } wr_t;

    function automatic logic [14:0] quarter_sine(input logic [6:0] i);
        logic [14:0] v;
        case (i)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd804;   7'd2:  v = 15'd1608;
            7'd3:  v = 15'd2410;  7'd4:  v = 15'd3212;  7'd5:  v = 15'd4011;
            7'd6:  v = 15'd4808;  7'd7:  v = 15'd5602;  7'd8:  v = 15'd6393;
            7'd9:  v = 15'd7179;  7'd10: v = 15'd7962;  7'd11: v = 15'd8739;
            7'd12: v = 15'd9512;  7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
            7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13278;
            7'd18: v = 15'd14010; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
            7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
            7'd24: v = 15'd18205; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
            7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
            7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
            7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
            7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
            7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
            7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
            7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
            7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
            7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
            7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
            7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
            7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
            7'd63: v = 15'd32757; 7'd64: v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sine_at(input logic [7:0] p);
        logic [14:0] q;
        logic [14:0] qm;
        logic signed [15:0] r;
        q  = quarter_sine({1'b0, p[5:0]});
        qm = quarter_sine(7'd64 - {1'b0, p[5:0]});
        case (p[7:6])
            2'd0:    r = $signed({1'b0, q});
            2'd1:    r = $signed({1'b0, qm});
            2'd2:    r = -$signed({1'b0, q});
            default: r = -$signed({1'b0, qm});
        endcase
        return r;
    endfunction

    function automatic logic [24:0] level_at(input logic [3:0] i);
        logic [8:0] v;
        case (i)
            4'd0:  v = 9'd256; 4'd1:  v = 9'd204; 4'd2:  v = 9'd168; 4'd3:  v = 9'd142;
            4'd4:  v = 9'd120; 4'd5:  v = 9'd102; 4'd6:  v = 9'd86;  4'd7:  v = 9'd73;
            4'd8:  v = 9'd61;  4'd9:  v = 9'd50;  4'd10: v = 9'd40;  4'd11: v = 9'd31;
            4'd12: v = 9'd22;  4'd13: v = 9'd14;  4'd14: v = 9'd7;
            default: v = 9'd0;
        endcase
        return {v, 16'd0};
    endfunction

endpackage

// File: design/psg_if.sv
// ----------------------------------------------------------------------------
// psg_in_if / psg_out_if
// Valid/ready channels carrying command items and stereo sample results.
// ----------------------------------------------------------------------------
interface psg_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [5:0]         reg_addr;
    logic [7:0]         reg_data;
    logic signed [15:0] bell_mix;

    modport source (output valid, command, reg_addr, reg_data, bell_mix, input ready);
    modport sink   (input valid, command, reg_addr, reg_data, bell_mix, output ready);
endinterface

interface psg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// File: design/psg_adsr_stereo_synth.sv
// ----------------------------------------------------------------------------
// psg_adsr_stereo_synth
// Multi-voice sound generator with ADSR envelopes and stereo panning.
// ----------------------------------------------------------------------------
// in_ch carries one item per transaction: a register byte write (command 0)
// or a sample tick (command 1). out_ch gives one stereo sample per tick.
// The voices sit in a ring of cells; a tick rotates the ring once, one voice
// per cycle through the shared update unit while the mix datapath reads the
// old sample and envelope of the same voice.
// A tick steps the ring in ST_TICK, once per voice, then passes ST_ACC and
// ST_FIN, which loads the result into the output register; in_ch is ready
// again in the next cycle. A write to a frequency byte works out the phase
// increment in ST_DIV by reciprocal multiplication and one correction step
// before the next item is taken. Other writes leave in_ch ready in ST_IDLE.
// Reset clears all voice registers and envelopes; noise generators get their seeds.
// If out_ch stalls, a finished result holds in the output register; writes
// are still taken, and the next tick waits until the held result is taken.
// ----------------------------------------------------------------------------
module psg_adsr_stereo_synth
#(
    parameter int VOICES      = psg_pkg::VOICES_DEF,
    parameter int SAMPLE_RATE = psg_pkg::SAMPLE_RATE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    psg_in_if.sink    in_ch,
    psg_out_if.source out_ch
);

    localparam int CW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [18:0] DIVISOR = 19'(3 * SAMPLE_RATE);
    localparam logic [33:0] RECIP   = 34'((64'd1 << 48) / 64'(3 * SAMPLE_RATE));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_TICK = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [5:0]  div_cnt_reg;
    logic [33:0] est_reg;
    logic [3:0]  div_voice_reg;

    psg_pkg::voice_t cell_rec [VOICES];
    psg_pkg::voice_t upd_rec;
    psg_pkg::wr_t    wr;
    logic            shift_en;
    logic            accept;
    logic            addr_ok;
    logic            div_done;
    logic [15:0]     freq;
    logic [49:0]     est_prod;
    logic [33:0]     est_next;
    logic [53:0]     chk_prod;
    logic            chk_ok;
    logic [31:0]     quo_next;

    logic signed [28:0] p1_reg;
    logic [6:0]  fl_reg, fr_reg;
    logic        mute_reg;
    logic        p1_valid_reg;
    logic signed [31:0] accl_reg, accr_reg;
    logic signed [15:0] bell_reg;
    logic        out_valid_reg;
    logic signed [15:0] outl_reg, outr_reg;

    logic signed [7:0]  pan_b;
    logic signed [7:0]  pan8;
    logic signed [7:0]  fl8, fr8;
    logic signed [29:0] rnd;
    logic signed [17:0] s_val;
    logic signed [25:0] pl, pr;
    logic signed [32:0] sl, sr;

    assign accept      = in_ch.valid && in_ch.ready;
    assign addr_ok     = {2'b00, in_ch.reg_addr} < 8'(VOICES * 8);
    assign shift_en    = (state_reg == ST_TICK);
    assign div_done    = (state_reg == ST_DIV) && (div_cnt_reg == 6'd1);

    always_comb
    begin
        wr.en   = accept && (in_ch.command == psg_pkg::CMD_WRITE) && addr_ok;
        wr.off  = in_ch.reg_addr[2:0];
        wr.data = in_ch.reg_data;
    end

    // ring of voice cells, head goes through the update unit into the tail
    genvar gi;
    generate
        for (gi = 0; gi < VOICES; gi++)
        begin : g_cell
            psg_pkg::voice_t sin;
            psg_pkg::wr_t    cwr;
            if (gi == VOICES - 1)
            begin : g_tail
                assign sin = upd_rec;
            end
            else
            begin : g_link
                assign sin = cell_rec[gi + 1];
            end
            always_comb
            begin
                cwr    = wr;
                cwr.en = wr.en && ({1'b0, in_ch.reg_addr[5:3]} == 4'(gi));
            end
            psg_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .shift_in (sin),
                .wr       (cwr),
                .inc_load (div_done && (div_voice_reg == 4'(gi))),
                .inc_val  (quo_next),
                .rec      (cell_rec[gi])
            );
        end
    endgenerate

    psg_voice #(.SAMPLE_RATE(SAMPLE_RATE)) u_voice
    (
        .cur (cell_rec[0]),
        .upd (upd_rec)
    );

    // freq * 2^32 / (3 * rate): reciprocal estimate is exact or one low, est_reg
    // holds it, then the check tests the next quotient and bumps it if it fits
    always_comb
    begin
        freq = {cell_rec[div_voice_reg[CW-1:0]].regs[psg_pkg::OFF_FREQ_HI],
                cell_rec[div_voice_reg[CW-1:0]].regs[psg_pkg::OFF_FREQ_LO]};
        est_prod = 50'(freq) * 50'(RECIP);
        est_next = est_prod[49:16];
        chk_prod = 54'({1'b0, est_reg} + 35'd1) * 54'(DIVISOR);
        chk_ok   = (chk_prod <= {6'd0, freq, 32'd0});
        quo_next = chk_ok ? est_reg[31:0] + 32'd1 : est_reg[31:0];
    end

    // mix datapath
    always_comb
    begin
        pan_b = $signed(cell_rec[0].regs[psg_pkg::OFF_PAN_GATE]);
        pan8  = (pan_b + $signed({7'd0, pan_b[7]})) >>> 1;
        fl8   = 8'sd63 - pan8;
        fr8   = 8'sd63 + pan8;
        rnd   = 30'(p1_reg) + 30'sd2048;
        s_val = 18'(rnd >>> 12);
        pl    = 26'(s_val) * 26'($signed({1'b0, fl_reg}));
        pr    = 26'(s_val) * 26'($signed({1'b0, fr_reg}));
        sl    = 33'((accl_reg + 32'sd64) >>> 7) + 33'(bell_reg);
        sr    = 33'((accr_reg + 32'sd64) >>> 7) + 33'(bell_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (in_ch.command == psg_pkg::CMD_TICK)
                        state_next = out_valid_reg ? ST_IDLE : ST_TICK;
                    else if (wr.en && (wr.off == psg_pkg::OFF_FREQ_LO ||
                                       wr.off == psg_pkg::OFF_FREQ_HI))
                        state_next = ST_DIV;
                end
            ST_DIV:
                if (div_done)
                    state_next = ST_IDLE;
            ST_TICK:
                if (cnt_reg == CW'(VOICES - 1))
                    state_next = ST_ACC;
            ST_ACC:
                state_next = ST_FIN;
            ST_FIN:
                if (!out_valid_reg || out_ch.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // a tick that arrives while a result is held is kept back by ready
    assign in_ch.ready = (state_reg == ST_IDLE) &&
                         !(in_ch.command == psg_pkg::CMD_TICK && out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            div_cnt_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= shift_en;
            if (accept)
            begin
                cnt_reg     <= '0;
                div_cnt_reg <= '0;
            end
            else
            begin
                if (shift_en)
                    cnt_reg <= cnt_reg + 1'b1;
                if (state_reg == ST_DIV)
                    div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (state_reg == ST_FIN && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            div_voice_reg <= {1'b0, in_ch.reg_addr[5:3]};
            bell_reg      <= in_ch.bell_mix;
            accl_reg      <= '0;
            accr_reg      <= '0;
        end
        else
        begin
            if (state_reg == ST_DIV && div_cnt_reg == 6'd0)
                est_reg <= est_next;
            if (p1_valid_reg && !mute_reg)
            begin
                accl_reg <= accl_reg + 32'(pl);
                accr_reg <= accr_reg + 32'(pr);
            end
        end
        p1_reg   <= 29'(cell_rec[0].sample) * 29'($signed({1'b0, cell_rec[0].env[24:12]}));
        fl_reg   <= fl8[6:0];
        fr_reg   <= fr8[6:0];
        mute_reg <= (pan8 == -8'sd64);
        if (state_reg == ST_FIN && (!out_valid_reg || out_ch.ready))
        begin
            outl_reg <= (sl > 33'sd32767) ? 16'sh7FFF :
                        (sl < -33'sd32768) ? 16'sh8000 : sl[15:0];
            outr_reg <= (sr > 33'sd32767) ? 16'sh7FFF :
                        (sr < -33'sd32768) ? 16'sh8000 : sr[15:0];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.left_sample  = outl_reg;
    assign out_ch.right_sample = outr_reg;

endmodule

// File: design/psg_cell.sv
// ----------------------------------------------------------------------------
// psg_cell
// One link of the voice ring: holds a voice record, takes register writes, shifts it on a tick.
// ----------------------------------------------------------------------------
module psg_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  psg_pkg::voice_t shift_in,
    input  psg_pkg::wr_t    wr,
    input  logic            inc_load,
    input  logic [31:0]     inc_val,
    output psg_pkg::voice_t rec
);

    localparam psg_pkg::voice_t REC_INIT = '{
        regs:   '0,
        inc:    '0,
        sample: '0,
        phase:  '0,
        env:    '0,
        stage:  psg_pkg::STG_RELEASE,
        nmix:   psg_pkg::NOISE_MIX_INIT,
        nout:   psg_pkg::NOISE_OUT_INIT,
        pend:   '0
    };

    psg_pkg::voice_t rec_reg;
    psg_pkg::voice_t rec_next;
    logic [2:0]      pend_next;

    always_comb
    begin
        pend_next = rec_reg.pend | 3'b001;
        if (wr.data[0])
            pend_next = pend_next | 3'b010;
        else
            pend_next = (pend_next & 3'b101) | 3'b100;
    end

    always_comb
    begin
        rec_next = rec_reg;
        if (shift_en)
        begin
            rec_next = shift_in;
        end
        else
        begin
            if (wr.en)
            begin
                rec_next.regs[wr.off] = wr.data;
                if (wr.off == psg_pkg::OFF_PAN_GATE)
                    rec_next.pend = pend_next;
            end
            if (inc_load)
                rec_next.inc = inc_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_reg <= REC_INIT;
        else
            rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

// File: design/psg_voice.sv
// ----------------------------------------------------------------------------
// psg_voice
// Per-voice update: phase, waveform, envelope step and gate edges.
// ----------------------------------------------------------------------------
module psg_voice
#(
    parameter int SAMPLE_RATE = psg_pkg::SAMPLE_RATE_DEF
)
(
    input  psg_pkg::voice_t cur,
    output psg_pkg::voice_t upd
);

    localparam int RK = SAMPLE_RATE / 1000;

    localparam logic [24:0] ATK_TAB [16] = '{
        25'((1 << 24) / (RK * 2)),    25'((1 << 24) / (RK * 8)),
        25'((1 << 24) / (RK * 16)),   25'((1 << 24) / (RK * 24)),
        25'((1 << 24) / (RK * 38)),   25'((1 << 24) / (RK * 56)),
        25'((1 << 24) / (RK * 68)),   25'((1 << 24) / (RK * 80)),
        25'((1 << 24) / (RK * 100)),  25'((1 << 24) / (RK * 250)),
        25'((1 << 24) / (RK * 500)),  25'((1 << 24) / (RK * 800)),
        25'((1 << 24) / (RK * 1000)), 25'((1 << 24) / (RK * 3000)),
        25'((1 << 24) / (RK * 5000)), 25'((1 << 24) / (RK * 8000))
    };

    localparam logic [24:0] FALL_TAB [16] = '{
        25'((1 << 24) / (RK * 6)),     25'((1 << 24) / (RK * 24)),
        25'((1 << 24) / (RK * 48)),    25'((1 << 24) / (RK * 72)),
        25'((1 << 24) / (RK * 114)),   25'((1 << 24) / (RK * 168)),
        25'((1 << 24) / (RK * 204)),   25'((1 << 24) / (RK * 240)),
        25'((1 << 24) / (RK * 300)),   25'((1 << 24) / (RK * 750)),
        25'((1 << 24) / (RK * 1500)),  25'((1 << 24) / (RK * 2400)),
        25'((1 << 24) / (RK * 3000)),  25'((1 << 24) / (RK * 9000)),
        25'((1 << 24) / (RK * 15000)), 25'((1 << 24) / (RK * 24000))
    };

    logic [31:0] acc;
    logic [7:0]  p;
    logic [7:0]  duty;
    logic [8:0]  lo_edge;
    logic [8:0]  hi_edge;
    logic        mid_closed;
    logic [31:0] mix_x;
    logic [24:0] peak;
    logic [24:0] hold;
    logic [24:0] dec;
    logic [25:0] sum;
    logic [24:0] lvl;
    logic [1:0]  stg;

    always_comb
    begin
        upd  = cur;
        acc  = cur.phase + cur.inc;
        p    = acc[31:24];
        duty = cur.regs[psg_pkg::OFF_DUTY];
        lo_edge = 9'd128 - {2'b00, duty[7:1]};
        hi_edge = 9'd128 + {2'b00, duty[7:1]};
        mid_closed = ({1'b0, p} < lo_edge) || ({1'b0, p} >= hi_edge);
        mix_x = cur.nmix ^ cur.nout;
        upd.phase = acc;

        case (cur.regs[psg_pkg::OFF_RELEASE][7:4])
            psg_pkg::WAVE_SINE:
                upd.sample = mid_closed ? psg_pkg::WAVE_RAIL : psg_pkg::sine_at(p);
            psg_pkg::WAVE_SQUARE:
                upd.sample = (p > duty) ? psg_pkg::WAVE_RAIL : psg_pkg::WAVE_PEAK;
            psg_pkg::WAVE_SAW:
                upd.sample = (p > duty) ? psg_pkg::WAVE_RAIL
                                        : $signed(16'h7FFF - acc[31:16]);
            psg_pkg::WAVE_TRIANGLE:
                if (mid_closed)
                    upd.sample = psg_pkg::WAVE_RAIL;
                else if (p[7])
                    upd.sample = $signed(16'h7FFF - acc[30:15]);
                else
                    upd.sample = $signed(acc[30:15] - 16'h8000);
            psg_pkg::WAVE_NOISE:
                if (p > duty)
                    upd.sample = psg_pkg::WAVE_RAIL;
                else
                begin
                    upd.nmix   = mix_x;
                    upd.sample = $signed(cur.nout[15:0]);
                    upd.nout   = cur.nout + mix_x;
                end
            default:
                upd.sample = '0;
        endcase

        // envelope
        peak = psg_pkg::level_at(cur.regs[psg_pkg::OFF_ATTACK][7:4]);
        hold = psg_pkg::level_at(cur.regs[psg_pkg::OFF_DECAY][7:4]);
        lvl  = cur.env;
        stg  = cur.stage;
        sum  = {1'b0, cur.env} + {1'b0, ATK_TAB[cur.regs[psg_pkg::OFF_ATTACK][3:0]]};
        dec  = '0;
        case (cur.stage)
            psg_pkg::STG_ATTACK:
            begin
                lvl = sum[24:0];
                if (sum >= {1'b0, peak})
                begin
                    lvl = peak;
                    stg = psg_pkg::STG_DECAY;
                end
            end
            psg_pkg::STG_DECAY:
            begin
                dec = FALL_TAB[cur.regs[psg_pkg::OFF_DECAY][3:0]];
                lvl = (cur.env <= dec) ? 25'd0 : cur.env - dec;
                if (lvl <= hold)
                begin
                    stg = psg_pkg::STG_SUSTAIN;
                    if (hold <= peak)
                        lvl = hold;
                end
            end
            psg_pkg::STG_SUSTAIN:
            begin
                if (hold <= peak)
                    lvl = hold;
            end
            default:
            begin
                dec = FALL_TAB[cur.regs[psg_pkg::OFF_RELEASE][3:0]];
                lvl = (cur.env <= dec) ? 25'd0 : cur.env - dec;
            end
        endcase
        upd.env = lvl;

        // pending gate edges, applied after the envelope step
        if (cur.pend[0])
        begin
            if (!cur.pend[1])
                stg = psg_pkg::STG_RELEASE;
            else if (cur.pend[2])
                stg = psg_pkg::STG_ATTACK;
            else if (stg == psg_pkg::STG_RELEASE)
                stg = psg_pkg::STG_ATTACK;
        end
        upd.stage = stg;
        upd.pend  = '0;
    end

endmodule
